[hdl/block_temporal_event_classifier_defines.svh]
// Assertion macros shared by the temporal event classifier RTL.
`ifndef BLOCK_TEMPORAL_EVENT_CLASSIFIER_DEFINES_SVH
`define BLOCK_TEMPORAL_EVENT_CLASSIFIER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define BTEC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define BTEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define BTEC_ASSERT_SAME(label, clk, rst, ante, cons)
`define BTEC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[hdl/btec_pkg.sv]
// Shared constants, codes and helpers for the temporal event classifier.
package btec_pkg;

  localparam int MAX_BLOCK_COLUMNS_DEF = 1024;
  localparam int SAMPLE_BITS_DEF       = 12;
  localparam int BLOCK_SIZE_DEF        = 4;

  localparam int MAX_FRAME_DIM   = 4096;
  localparam int MEAN_DIFF_LIMIT = 8;
  localparam int FRAME_DIM_RST   = 64;

  localparam int DIM_W      = 13;
  localparam int POS_W      = 12;
  localparam int DS_W       = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int EVT_W      = 2;
  localparam int BIDX_OUT_W = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_DEPTH_SHIFT    = 2'd2,
    REG_PREVIOUS_VALID = 2'd3
  } cfg_reg_t;

  localparam logic [EVT_W-1:0] EVT_STABLE = 2'd0;
  localparam logic [EVT_W-1:0] EVT_ON     = 2'd1;
  localparam logic [EVT_W-1:0] EVT_OFF    = 2'd2;

  // Index of the last pixel along one axis; zero acts as one, oversize as the maximum.
  function automatic logic [POS_W-1:0] last_index(input logic [DIM_W-1:0] dim);
    logic [DIM_W-1:0] dm1;
    dm1 = dim - DIM_W'(1);
    if (dim == '0) begin
      last_index = '0;
    end else if (dim > DIM_W'(MAX_FRAME_DIM)) begin
      last_index = POS_W'(MAX_FRAME_DIM - 1);
    end else begin
      last_index = dm1[POS_W-1:0];
    end
  endfunction

endpackage

[hdl/btec_ifs.sv]
// Valid/ready channel interfaces for sample pairs and block events.
interface btec_sample_if #(
  parameter int SAMPLE_BITS = 12
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] current_sample;
  logic [SAMPLE_BITS-1:0] previous_sample;

  modport source (output valid, output current_sample, output previous_sample, input ready);
  modport sink (input valid, input current_sample, input previous_sample, output ready);
endinterface

interface btec_event_if ();
  logic       valid;
  logic       ready;
  logic [1:0] event_code;
  logic [9:0] block_column;
  logic [9:0] block_row;

  modport source (output valid, output event_code, output block_column, output block_row,
                  input ready);
  modport sink (input valid, input event_code, input block_column, input block_row,
                output ready);
endinterface

[hdl/btec_acc_mem.sv]
// Per-block-column accumulator memory with registered read and write-through bypass.
module btec_acc_mem
  import btec_pkg::*;
#(
  parameter int DEPTH  = MAX_BLOCK_COLUMNS_DEF,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 33
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A read that meets a write to the same entry returns the new word.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

[hdl/block_temporal_event_classifier.sv]
// An event word passes stage 1, stage 2 and the output register after its block's last
// pixel is taken, delayed by any held stage or output. Throughput: one sample pair per cycle
// unless a stage is held; a block is summed in row segments, and its column accumulator
// (one read, one write port) is written once per segment and read once per non-top segment.
// Synchronous reset clears the raster position, all stage valids and the registers to
// their defaults; the accumulator memory is not cleared (each block's top row sets it).
`include "block_temporal_event_classifier_defines.svh"

module block_temporal_event_classifier
  import btec_pkg::*;
#(
  parameter int MAX_BLOCK_COLUMNS = MAX_BLOCK_COLUMNS_DEF,
  parameter int SAMPLE_BITS       = SAMPLE_BITS_DEF,
  parameter int BLOCK_SIZE        = BLOCK_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  btec_sample_if.sink           samples,
  btec_event_if.source          events
);

  localparam int SB        = SAMPLE_BITS;
  localparam int BB        = BLOCK_SIZE * BLOCK_SIZE;
  localparam int SUB_W     = $clog2(BLOCK_SIZE);
  localparam int SLOT_W    = (MAX_BLOCK_COLUMNS > 1) ? $clog2(MAX_BLOCK_COLUMNS) : 1;
  localparam int BIDX_RAW  = $clog2((MAX_FRAME_DIM - 1) / BLOCK_SIZE + 1);
  localparam int BIDX_W    = (BIDX_RAW > BIDX_OUT_W) ? BIDX_RAW : BIDX_OUT_W;
  localparam int SEG_SUM_W = SB + 1 + $clog2(BLOCK_SIZE);
  localparam int SEG_ABS_W = SB + $clog2(BLOCK_SIZE);
  localparam int SUM_W     = SB + 1 + $clog2(BB);
  localparam int ABS_W     = SB + $clog2(BB);
  localparam int THR_W     = $clog2(MEAN_DIFF_LIMIT * BB + 1) + (1 << DS_W) - 1;
  localparam int CMP_W     = (THR_W > ABS_W) ? THR_W : ABS_W;
  localparam int ACC_W     = SUM_W + ABS_W;

  // Configuration registers.
  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic [DS_W-1:0]  depth_shift;
  logic             previous_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= DIM_W'(FRAME_DIM_RST);
      frame_height   <= DIM_W'(FRAME_DIM_RST);
      depth_shift    <= '0;
      previous_valid <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:    frame_width    <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT:   frame_height   <= cfg_data[DIM_W-1:0];
        REG_DEPTH_SHIFT:    depth_shift    <= cfg_data[DS_W-1:0];
        REG_PREVIOUS_VALID: previous_valid <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Raster position, kept both as pixel counts and as block coordinates.
  logic [POS_W-1:0]  col, row;
  logic [SUB_W-1:0]  sub_col, sub_row;
  logic [BIDX_W-1:0] bcol, brow;
  logic [SLOT_W-1:0] slot;
  logic [POS_W-1:0]  col_last, row_last;
  logic              row_end, frame_end, col_blk_end, row_blk_end;
  logic              acc_ok;

  assign col_last    = last_index(frame_width);
  assign row_last    = last_index(frame_height);
  assign row_end     = (col >= col_last);
  assign frame_end   = (row >= row_last);
  assign col_blk_end = (sub_col == SUB_W'(BLOCK_SIZE - 1));
  assign row_blk_end = (sub_row == SUB_W'(BLOCK_SIZE - 1));
  assign acc_ok      = samples.valid && samples.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row     <= '0;
      sub_col <= '0;
      sub_row <= '0;
      bcol    <= '0;
      brow    <= '0;
      slot    <= '0;
    end else if (acc_ok) begin
      if (row_end) begin
        col     <= '0;
        sub_col <= '0;
        bcol    <= '0;
        slot    <= '0;
        if (frame_end) begin
          row     <= '0;
          sub_row <= '0;
          brow    <= '0;
        end else begin
          row <= row + POS_W'(1);
          if (row_blk_end) begin
            sub_row <= '0;
            brow    <= brow + BIDX_W'(1);
          end else begin
            sub_row <= sub_row + SUB_W'(1);
          end
        end
      end else begin
        col <= col + POS_W'(1);
        if (col_blk_end) begin
          sub_col <= '0;
          bcol    <= bcol + BIDX_W'(1);
          slot    <= (slot == SLOT_W'(MAX_BLOCK_COLUMNS - 1)) ? '0 : slot + SLOT_W'(1);
        end else begin
          sub_col <= sub_col + SUB_W'(1);
        end
      end
    end
  end

  // Stage 1: registered sample pair and its place in the block.
  logic                  s1_valid;
  logic [SB-1:0]         s1_cur, s1_prev;
  logic                  s1_seg_start, s1_seg_end, s1_top, s1_emit, s1_full;
  logic [SLOT_W-1:0]     s1_slot;
  logic [BIDX_OUT_W-1:0] s1_bcol, s1_brow;
  logic                  s1_adv, s1_free;

  // Stage 2: finished row segment on its way into the accumulator.
  logic                        s2_valid;
  logic signed [SEG_SUM_W-1:0] s2_seg_sum;
  logic [SEG_ABS_W-1:0]        s2_seg_abs;
  logic                        s2_top, s2_emit, s2_full;
  logic [SLOT_W-1:0]           s2_slot;
  logic [BIDX_OUT_W-1:0]       s2_bcol, s2_brow;
  logic                        s2_adv, s2_free;

  // Output register.
  logic                  o_valid;
  logic [EVT_W-1:0]      o_code;
  logic [BIDX_OUT_W-1:0] o_bcol, o_brow;
  logic                  o_free;

  assign o_free        = !o_valid || events.ready;
  assign s2_adv        = s2_valid && (!s2_emit || o_free);
  assign s2_free       = !s2_valid || s2_adv;
  assign s1_adv        = s1_valid && (!s1_seg_end || s2_free);
  assign s1_free       = !s1_valid || s1_adv;
  assign samples.ready = s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_ok) begin
      s1_cur       <= samples.current_sample;
      s1_prev      <= samples.previous_sample;
      s1_seg_start <= (sub_col == '0);
      s1_seg_end   <= col_blk_end || row_end;
      s1_top       <= (sub_row == '0);
      s1_emit      <= (col_blk_end || row_end) && (row_blk_end || frame_end);
      s1_full      <= col_blk_end && row_blk_end;
      s1_slot      <= slot;
      s1_bcol      <= bcol[BIDX_OUT_W-1:0];
      s1_brow      <= brow[BIDX_OUT_W-1:0];
    end
  end

  // Difference of the pair and the running sums of the current row segment.
  logic signed [SB:0]          diff, neg_diff;
  logic [SB-1:0]               abs_diff;
  logic signed [SEG_SUM_W-1:0] seg_sum, seg_sum_next;
  logic [SEG_ABS_W-1:0]        seg_abs, seg_abs_next;

  always_comb begin
    diff     = $signed({1'b0, s1_cur}) - $signed({1'b0, s1_prev});
    neg_diff = -diff;
    abs_diff = diff[SB] ? neg_diff[SB-1:0] : diff[SB-1:0];
    if (s1_seg_start) begin
      seg_sum_next = SEG_SUM_W'(diff);
      seg_abs_next = SEG_ABS_W'(abs_diff);
    end else begin
      seg_sum_next = seg_sum + SEG_SUM_W'(diff);
      seg_abs_next = seg_abs + SEG_ABS_W'(abs_diff);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && !s1_seg_end) begin
      seg_sum <= seg_sum_next;
      seg_abs <= seg_abs_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_adv && s1_seg_end;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_seg_end) begin
      s2_seg_sum <= seg_sum_next;
      s2_seg_abs <= seg_abs_next;
      s2_top     <= s1_top;
      s2_emit    <= s1_emit;
      s2_full    <= s1_full;
      s2_slot    <= s1_slot;
      s2_bcol    <= s1_bcol;
      s2_brow    <= s1_brow;
    end
  end

  // Block totals: the top row of a block starts the accumulator afresh.
  logic [ACC_W-1:0]        rd_data, wr_data;
  logic signed [SUM_W-1:0] rd_sum, tot_sum;
  logic [ABS_W-1:0]        rd_abs, tot_abs;
  logic [THR_W-1:0]        thr;
  logic                    changed;
  logic [EVT_W-1:0]        code_next;

  assign rd_sum  = rd_data[ABS_W +: SUM_W];
  assign rd_abs  = rd_data[ABS_W-1:0];
  assign wr_data = {tot_sum, tot_abs};

  btec_acc_mem #(
    .DEPTH  (MAX_BLOCK_COLUMNS),
    .ADDR_W (SLOT_W),
    .DATA_W (ACC_W)
  ) u_acc_mem (
    .clk     (clk),
    .wr_en   (s2_adv),
    .wr_addr (s2_slot),
    .wr_data (wr_data),
    .rd_en   (s1_adv && s1_seg_end && !s1_top),
    .rd_addr (s1_slot),
    .rd_data (rd_data)
  );

  always_comb begin
    if (s2_top) begin
      tot_sum = SUM_W'(s2_seg_sum);
      tot_abs = ABS_W'(s2_seg_abs);
    end else begin
      tot_sum = rd_sum + SUM_W'(s2_seg_sum);
      tot_abs = rd_abs + ABS_W'(s2_seg_abs);
    end
    // floor(abs / BB) >= T is the same test as abs >= T * BB.
    thr     = THR_W'(MEAN_DIFF_LIMIT * BB) << depth_shift;
    changed = (CMP_W'(tot_abs) >= CMP_W'(thr));
    if (s2_full && previous_valid && changed) begin
      code_next = (tot_sum > 0) ? EVT_ON : EVT_OFF;
    end else begin
      code_next = EVT_STABLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_free) begin
      o_valid <= s2_adv && s2_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (o_free && s2_adv && s2_emit) begin
      o_code <= code_next;
      o_bcol <= s2_bcol;
      o_brow <= s2_brow;
    end
  end

  assign events.valid        = o_valid;
  assign events.event_code   = o_code;
  assign events.block_column = o_bcol;
  assign events.block_row    = o_brow;

  `BTEC_ASSERT_NEXT(a_row_wrap, clk, rst, acc_ok && row_end && !frame_end,
                    col == '0 && row == $past(row) + POS_W'(1))
  `BTEC_ASSERT_NEXT(a_block_step, clk, rst, acc_ok && col_blk_end && !row_end,
                    sub_col == '0 && bcol == $past(bcol) + BIDX_W'(1))
  `BTEC_ASSERT_NEXT(a_emit_lands, clk, rst, s2_adv && s2_emit, o_valid)
  `BTEC_ASSERT_SAME(a_seg_order, clk, rst, s1_adv && s1_seg_end && s2_valid, s2_adv)

endmodule

[sim/tb_block_temporal_event_classifier.sv]
// Self-checking testbench for the 4x4 block temporal event classifier, with a raster predictor.
`timescale 1ns / 100ps

module tb_block_temporal_event_classifier
  import btec_pkg::*;
;

  localparam int BLK          = BLOCK_SIZE_DEF;
  localparam int ACC_SLOTS    = MAX_BLOCK_COLUMNS_DEF;
  localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS_DEF) - 1;
  localparam int PIPE_LATENCY = 3;
  localparam int DRAIN_SLACK  = PIPE_LATENCY + 6;
  localparam int STALL_LIMIT  = 5000;
  localparam int RANDOM_ITEMS = 880;
  localparam int PRINT_CAP    = 40;

  typedef enum int {
    FRAME_RANDOM,
    FRAME_SATURATED,
    FRAME_THRESHOLD
  } frame_style_t;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic [SAMPLE_BITS_DEF-1:0] cur;
    logic [SAMPLE_BITS_DEF-1:0] prev;
  } sample_pair_t;

  typedef struct packed {
    logic [EVT_W-1:0]      code;
    logic [BIDX_OUT_W-1:0] column;
    logic [BIDX_OUT_W-1:0] row;
  } block_event_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic                       drv_valid = 1'b0;
  logic [SAMPLE_BITS_DEF-1:0] drv_cur = '0;
  logic [SAMPLE_BITS_DEF-1:0] drv_prev = '0;
  logic                       evt_ready = 1'b0;

  btec_sample_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) sample_ch ();
  btec_event_if event_ch ();

  assign sample_ch.valid           = drv_valid;
  assign sample_ch.current_sample  = drv_cur;
  assign sample_ch.previous_sample = drv_prev;
  assign event_ch.ready            = evt_ready;

  block_temporal_event_classifier u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (sample_ch),
    .events    (event_ch)
  );

  // Predictor copy of the registers and the raster state.
  logic [DIM_W-1:0] cfg_width = 13'(FRAME_DIM_RST);
  logic [DIM_W-1:0] cfg_height = 13'(FRAME_DIM_RST);
  logic [DS_W-1:0]  cfg_shift = '0;
  logic             cfg_prev_valid = 1'b0;
  int               signed_sums [ACC_SLOTS];
  int               absolute_sums [ACC_SLOTS];
  int               pix_col = 0;
  int               pix_row = 0;

  sample_pair_t pending_pairs [$];
  block_event_t predicted_events [$];
  int           block_mode [ACC_SLOTS];
  int           mismatch_count = 0;
  int           quiet_cycles = 0;
  int           send_idle_pct = 0;
  int           stall_pct = 0;

  sample_pair_t next_pair;
  logic         pair_taken;
  block_event_t awaited;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int effective_dim(input logic [DIM_W-1:0] dim);
    if (dim == '0) return 1;
    if (dim > DIM_W'(MAX_FRAME_DIM)) return MAX_FRAME_DIM;
    return int'(dim);
  endfunction

  function automatic int clip_sample(input int v);
    if (v < 0) return 0;
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Accumulates one sample pair into its block column and predicts the block's event
  // when the pair closes a block.
  task automatic predict_block_event(input logic [SAMPLE_BITS_DEF-1:0] cur,
                                     input logic [SAMPLE_BITS_DEF-1:0] prev);
    int w, h, col, row, bcol, slot, d, ad, thresh;
    bit row_end, frame_end, full;
    block_event_t ev;
    w = effective_dim(cfg_width);
    h = effective_dim(cfg_height);
    col = pix_col;
    row = pix_row;
    row_end = col >= w - 1;
    frame_end = row >= h - 1;
    bcol = col / BLK;
    slot = bcol % ACC_SLOTS;
    d = int'(cur) - int'(prev);
    ad = (d < 0) ? -d : d;
    if (row % BLK == 0 && col % BLK == 0) begin
      signed_sums[slot] = d;
      absolute_sums[slot] = ad;
    end else begin
      signed_sums[slot] += d;
      absolute_sums[slot] += ad;
    end
    if ((col % BLK == BLK - 1 || row_end) && (row % BLK == BLK - 1 || frame_end)) begin
      full = (col % BLK == BLK - 1) && (row % BLK == BLK - 1);
      ev.code = EVT_STABLE;
      if (full && cfg_prev_valid) begin
        thresh = MEAN_DIFF_LIMIT << cfg_shift;
        if (absolute_sums[slot] / (BLK * BLK) >= thresh) begin
          ev.code = (signed_sums[slot] > 0) ? EVT_ON : EVT_OFF;
        end
      end
      ev.column = BIDX_OUT_W'(bcol);
      ev.row = BIDX_OUT_W'(row / BLK);
      predicted_events.push_back(ev);
    end
    if (row_end) begin
      pix_col = 0;
      pix_row = frame_end ? 0 : row + 1;
    end else begin
      pix_col = col + 1;
    end
  endtask

  // Queues one whole frame at the current geometry, so that every phase ends at row 0.
  task automatic queue_frame(input frame_style_t style);
    int w, h, thr, r, c, d, p, q;
    sample_pair_t pair;
    w = effective_dim(cfg_width);
    h = effective_dim(cfg_height);
    thr = MEAN_DIFF_LIMIT << cfg_shift;
    for (r = 0; r < h; r++) begin
      for (c = 0; c < w; c++) begin
        if (r % BLK == 0 && c % BLK == 0) block_mode[c / BLK] = $urandom_range(4, 0);
        case (style)
          FRAME_SATURATED: begin
            p = ((c / BLK) % 2 == 0) ? SAMPLE_MAX : 0;
            q = SAMPLE_MAX - p;
          end
          FRAME_THRESHOLD: begin
            // Net-zero block at the threshold, block exactly at it, block one below it.
            q = $urandom_range(SAMPLE_MAX - thr, thr);
            case ((c / BLK) % 3)
              0: d = ((r + c) % 2 == 0) ? thr : -thr;
              1: d = thr;
              default: d = (r % BLK == BLK - 1 && c % BLK == BLK - 1) ? thr - 1 : thr;
            endcase
            p = q + d;
          end
          default: begin
            q = $urandom_range(SAMPLE_MAX, 0);
            case (block_mode[c / BLK])
              0: p = $urandom_range(SAMPLE_MAX, 0);
              1: p = clip_sample(q + int'($urandom_range(2 * thr, thr / 2)));
              2: p = clip_sample(q - int'($urandom_range(2 * thr, thr / 2)));
              3: begin
                d = $urandom_range(2 * thr, 0);
                if ($urandom_range(1, 0) == 1) d = -d;
                p = clip_sample(q + d);
              end
              default: begin
                p = ($urandom_range(1, 0) == 1) ? SAMPLE_MAX : 0;
                q = SAMPLE_MAX - p;
              end
            endcase
          end
        endcase
        pair.cur = SAMPLE_BITS_DEF'(p);
        pair.prev = SAMPLE_BITS_DEF'(q);
        pending_pairs.push_back(pair);
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_pairs.size() != 0 || drv_valid || predicted_events.size() != 0) begin
      @(posedge clk);
    end
    // Trailing words of a cut-off block may still be in flight without any event.
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_FRAME_WIDTH:    cfg_width = value;
      REG_FRAME_HEIGHT:   cfg_height = value;
      REG_DEPTH_SHIFT:    cfg_shift = value[DS_W-1:0];
      REG_PREVIOUS_VALID: cfg_prev_valid = value[0];
      default: ;
    endcase
  endtask

  task automatic run_phase(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                           input logic [DS_W-1:0] ds, input logic pv, input int frames,
                           input frame_style_t style, input idle_mode_t idling);
    wait_drained();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_DEPTH_SHIFT, CFG_DATA_W'(ds));
    write_reg(REG_PREVIOUS_VALID, CFG_DATA_W'(pv));
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk);
    case (idling)
      IDLE_SENDER:   begin send_idle_pct = 75; stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 75; end
      IDLE_BOTH:     begin send_idle_pct = 37; stall_pct = 37; end
      default:       begin send_idle_pct = 0;  stall_pct = 0;  end
    endcase
    repeat (frames) queue_frame(style);
  endtask

  // Sample driver: holds a word until it is taken, then offers the next one or idles.
  always @(posedge clk) begin
    if (rst) begin
      drv_valid <= 1'b0;
    end else begin
      pair_taken = drv_valid && sample_ch.ready;
      if (pair_taken) predict_block_event(drv_cur, drv_prev);
      if (!drv_valid || pair_taken) begin
        if (pending_pairs.size() != 0 && int'($urandom_range(99, 0)) >= send_idle_pct) begin
          next_pair = pending_pairs.pop_front();
          drv_cur <= next_pair.cur;
          drv_prev <= next_pair.prev;
          drv_valid <= 1'b1;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // Event monitor: checks each taken word against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      evt_ready <= 1'b0;
    end else begin
      if (event_ch.valid && evt_ready) begin
        if (predicted_events.size() == 0) begin
          report_mismatch($sformatf("event word (code %0d, column %0d, row %0d) not expected",
                                    event_ch.event_code, event_ch.block_column,
                                    event_ch.block_row));
        end else begin
          awaited = predicted_events.pop_front();
          if (event_ch.event_code !== awaited.code) begin
            report_mismatch($sformatf("event_code got %0d, expected %0d (block %0d,%0d)",
                                      event_ch.event_code, awaited.code, awaited.column,
                                      awaited.row));
          end
          if (event_ch.block_column !== awaited.column) begin
            report_mismatch($sformatf("block_column got %0d, expected %0d",
                                      event_ch.block_column, awaited.column));
          end
          if (event_ch.block_row !== awaited.row) begin
            report_mismatch($sformatf("block_row got %0d, expected %0d",
                                      event_ch.block_row, awaited.row));
          end
        end
      end
      evt_ready <= int'($urandom_range(99, 0)) >= stall_pct;
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (drv_valid && sample_ch.ready) || (event_ch.valid && evt_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int phase_no;
    int random_items;
    int frames;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [DS_W-1:0] ds;
    logic pv;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames: full-scale on and off blocks, threshold corners, no previous frame.
    run_phase(13'd8, 13'd4, 3'd0, 1'b1, 1, FRAME_SATURATED, IDLE_NONE);
    run_phase(13'd12, 13'd4, 3'd0, 1'b1, 1, FRAME_THRESHOLD, IDLE_NONE);
    run_phase(13'd4, 13'd4, 3'd0, 1'b0, 1, FRAME_SATURATED, IDLE_NONE);
    run_phase(13'd12, 13'd4, 3'd7, 1'b1, 1, FRAME_THRESHOLD, IDLE_BOTH);
    run_phase(13'd6, 13'd5, 3'd0, 1'b1, 1, FRAME_SATURATED, IDLE_SENDER);

    // Zero sizes act as a single pixel.
    run_phase(13'd0, 13'd0, 3'd0, 1'b1, 5, FRAME_RANDOM, IDLE_RECEIVER);

    phase_no = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      w = DIM_W'($urandom_range(24, 1));
      h = DIM_W'($urandom_range(12, 1));
      if ($urandom_range(15, 0) == 0) w = '0;
      if ($urandom_range(15, 0) == 0) h = '0;
      ds = ($urandom_range(3, 0) == 0) ? DS_W'($urandom_range(7, 0))
                                       : DS_W'($urandom_range(2, 0));
      pv = $urandom_range(7, 0) != 0;
      frames = $urandom_range(3, 1);
      run_phase(w, h, ds, pv, frames, FRAME_RANDOM, idle_mode_t'(phase_no % 4));
      random_items += frames * effective_dim(w) * effective_dim(h);
      phase_no++;
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/btec_pkg.sv
hdl/btec_ifs.sv
hdl/btec_acc_mem.sv
hdl/block_temporal_event_classifier.sv
sim/tb_block_temporal_event_classifier.sv
